>>> hw/rtl/address_table_with_stale_replace_assert.svh
// assertion macros for the address table checker
// expects clk and arst_n in the scope of use; no other dependencies
`ifndef ADDRESS_TABLE_WITH_STALE_REPLACE_ASSERT_SVH
`define ADDRESS_TABLE_WITH_STALE_REPLACE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ATT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define ATT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/att_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the address table
// no dependencies
package att_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam logic [31:0] STALE_RESET = 32'd30000;

	localparam logic CMD_SIGHT = 1'b0;
	localparam logic CMD_SWEEP = 1'b1;

	typedef enum logic [1:0] {
		OUT_REFRESH = 2'd0,
		OUT_INSERT  = 2'd1,
		OUT_REPLACE = 2'd2,
		OUT_SWEEP   = 2'd3
	} outcome_t;

	// one table entry as stored in the entry memory
	typedef struct packed {
		logic [47:0] address;
		logic [7:0]  strength;
		logic [3:0]  kind;
		logic        lost;
		logic [31:0] last_seen;
	} entry_t;

	// finished request handed to the output register
	typedef struct packed {
		outcome_t    outcome;
		logic [3:0]  slot;
		logic [4:0]  live;
		logic [4:0]  dropped;
	} result_t;

endpackage

>>> hw/rtl/att_ram.sv
`timescale 1ns / 1ps
// entry memory: one write port, one read port, registered read data
// depends on att_pkg
module att_ram #(
	parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
	input  att_pkg::entry_t                wdata,
	input  logic                           re,
	input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
	output att_pkg::entry_t                rdata
);

	att_pkg::entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/att_seq.sv
`timescale 1ns / 1ps
// request sequencer: walks the entry memory for lookup, stalest search and sweep
// depends on att_pkg and att_ram
module att_seq #(
	parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [47:0]        address,
	input  logic signed [7:0]  signal_strength,
	input  logic [3:0]         device_kind,
	input  logic               lost_flag,
	input  logic [31:0]        now_ms,
	input  logic [31:0]        stale_limit,
	output logic               res_valid,
	input  logic               res_take,
	output att_pkg::result_t   res
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	state_t             state_q;
	logic               cmd_q;
	att_pkg::entry_t    in_entry_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_idx_q;
	logic [CW-1:0]      w_q;
	logic [CW-1:0]      dropped_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [31:0]        min_time_q;
	logic [IW-1:0]      min_idx_q;
	logic [IW-1:0]      slot_q;
	att_pkg::outcome_t  outcome_q;

	att_pkg::entry_t    rd_entry;
	att_pkg::entry_t    wr_entry;
	logic               issue;
	logic               proc_s1;
	logic               hit;
	logic               last;
	logic               take_min;
	logic [IW-1:0]      new_min_idx;
	logic [31:0]        age;
	logic               keep;
	logic [CW-1:0]      w_next;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;

	att_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (rd_entry)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	assign issue       = (state_q == S_SCAN) && (rd_idx_q < n_q);
	assign proc_s1     = (state_q == S_SCAN) && rd_vld_s1;
	assign hit         = (rd_entry.address == in_entry_q.address);
	assign last        = ((CW'(idx_s1) + CW'(1)) == n_q);
	assign take_min    = (idx_s1 == '0) || (rd_entry.last_seen < min_time_q);
	assign new_min_idx = take_min ? idx_s1 : min_idx_q;
	// wrapping age against the request time
	assign age         = in_entry_q.last_seen - rd_entry.last_seen;
	assign keep        = (age <= stale_limit);
	assign w_next      = w_q + CW'(keep);

	// sweep packs survivors down; sighting writes its slot once the walk is over
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		wr_entry  = in_entry_q;
		if (state_q == S_WRITE) begin
			ram_we = 1'b1;
		end else if (proc_s1 && (cmd_q == att_pkg::CMD_SWEEP) && keep) begin
			ram_we    = 1'b1;
			ram_waddr = w_q[IW-1:0];
			wr_entry  = rd_entry;
		end
	end

	assign res.outcome = outcome_q;
	assign res.slot    = 4'(slot_q);
	assign res.live    = 5'(count_q);
	assign res.dropped = 5'(dropped_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q                <= cmd;
						in_entry_q.address   <= address;
						in_entry_q.strength  <= $unsigned(signal_strength);
						in_entry_q.kind      <= device_kind;
						in_entry_q.lost      <= lost_flag;
						in_entry_q.last_seen <= now_ms;
						n_q                  <= count_q;
						rd_idx_q             <= '0;
						w_q                  <= '0;
						dropped_q            <= '0;
						slot_q               <= '0;
						if (count_q == '0) begin
							if (cmd == att_pkg::CMD_SIGHT) begin
								outcome_q <= att_pkg::OUT_INSERT;
								count_q   <= CW'(1);
								state_q   <= S_WRITE;
							end else begin
								outcome_q <= att_pkg::OUT_SWEEP;
								state_q   <= S_DONE;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					idx_s1 <= rd_idx_q[IW-1:0];
					if (proc_s1) begin
						if (cmd_q == att_pkg::CMD_SIGHT) begin
							min_time_q <= take_min ? rd_entry.last_seen : min_time_q;
							min_idx_q  <= new_min_idx;
							if (hit) begin
								slot_q    <= idx_s1;
								outcome_q <= att_pkg::OUT_REFRESH;
								state_q   <= S_WRITE;
							end else if (last) begin
								if (n_q < CW'(TABLE_DEPTH)) begin
									slot_q    <= n_q[IW-1:0];
									outcome_q <= att_pkg::OUT_INSERT;
									count_q   <= n_q + CW'(1);
								end else begin
									slot_q    <= new_min_idx;
									outcome_q <= att_pkg::OUT_REPLACE;
								end
								state_q <= S_WRITE;
							end
						end else begin
							w_q <= w_next;
							if (last) begin
								count_q   <= w_next;
								dropped_q <= n_q - w_next;
								outcome_q <= att_pkg::OUT_SWEEP;
								slot_q    <= '0;
								state_q   <= S_DONE;
							end
						end
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/address_table_with_stale_replace.sv
`timescale 1ns / 1ps
// top level of the address table: stale limit register, sequencer, output register
// depends on att_pkg and att_seq
//
// usage
//  - input channel in_valid/in_ready carries one request: a sighting (cmd 0) looks up
//    address, refreshes a hit, fills the next free slot or replaces the lowest-time entry;
//    an age sweep (cmd 1) drops entries older than the stale limit at now_ms and packs
//    the survivors towards slot 0, keeping their order
//  - output channel out_valid/out_ready returns one result per request: outcome,
//    slot_index, live_entries and dropped_entries
//  - cfg_wr_en/cfg_wr_data write the stale limit; write it only while idle
//  - one request is worked on at a time; the walk reads one entry per cycle through the
//    single read port of the entry memory, and a hit ends the walk early
//  - the next request is accepted once the previous result has moved into the output
//    register, so it is taken while that result still waits on out_ready
//  - if the receiver stalls, the finished result holds in the sequencer until the output
//    register frees up; nothing is dropped
//  - reset empties the table (live count 0) and sets the stale limit to 30000 ms; the
//    entry memory itself is not cleared, as only slots below the live count are read
module address_table_with_stale_replace #(
	parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [47:0]       address,
	input  logic signed [7:0] signal_strength,
	input  logic [3:0]        device_kind,
	input  logic              lost_flag,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        outcome,
	output logic [3:0]        slot_index,
	output logic [4:0]        live_entries,
	output logic [4:0]        dropped_entries,
	input  logic              cfg_wr_en,
	input  logic [31:0]       cfg_wr_data
);

	logic [31:0]       stale_limit_q;
	logic              out_valid_q;
	att_pkg::result_t  out_res_q;
	logic              res_valid;
	logic              res_take;
	att_pkg::result_t  res;

	// output register is free when empty or being drained this cycle
	assign res_take = !out_valid_q || out_ready;

	att_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.address         (address),
		.signal_strength (signal_strength),
		.device_kind     (device_kind),
		.lost_flag       (lost_flag),
		.now_ms          (now_ms),
		.stale_limit     (stale_limit_q),
		.res_valid       (res_valid),
		.res_take        (res_take),
		.res             (res)
	);

	// stale limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= att_pkg::STALE_RESET;
		end else if (cfg_wr_en) begin
			stale_limit_q <= cfg_wr_data;
		end
	end

	// output register, decouples the receiver from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign outcome         = out_res_q.outcome;
	assign slot_index      = out_res_q.slot;
	assign live_entries    = out_res_q.live;
	assign dropped_entries = out_res_q.dropped;

endmodule

>>> hw/rtl/att_checker.sv
`timescale 1ns / 1ps
// port-level checks on the result channel of the address table, bound to the top level
// depends on att_pkg and address_table_with_stale_replace_assert.svh
`include "address_table_with_stale_replace_assert.svh"

module att_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] outcome,
	input logic [3:0] slot_index,
	input logic [4:0] live_entries,
	input logic [4:0] dropped_entries
);

	// a stalled result keeps its payload
	`ATT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(slot_index) && $stable(live_entries) && $stable(dropped_entries), "result changed while stalled")

	// only a sweep drops entries
	`ATT_ASSERT_NOW(a_drop_sweep_only, out_valid && (outcome != att_pkg::OUT_SWEEP), dropped_entries == 5'd0, "sighting reported dropped entries")

	// a sweep reports slot zero
	`ATT_ASSERT_NOW(a_sweep_slot, out_valid && (outcome == att_pkg::OUT_SWEEP), slot_index == 4'd0, "sweep reported a nonzero slot")

	// an insert lands in the slot numbered by the old live count, one below the new count
	`ATT_ASSERT_NOW(a_insert_slot, out_valid && (outcome == att_pkg::OUT_INSERT), slot_index == 4'(live_entries - 5'd1), "insert slot does not match live count")

endmodule

bind address_table_with_stale_replace att_checker u_att_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.outcome         (outcome),
	.slot_index      (slot_index),
	.live_entries    (live_entries),
	.dropped_entries (dropped_entries)
);

>>> tb/sv/address_table_with_stale_replace_tb.sv
`timescale 1ns / 1ps
// self-checking bench for address_table_with_stale_replace: directed table, then random phases
// depends on att_pkg and the address_table_with_stale_replace rtl only
module address_table_with_stale_replace_tb;
	import att_pkg::*;

	// one request as offered on the input channel
	typedef struct packed {
		logic              cmd;
		logic [47:0]       address;
		logic signed [7:0] strength;
		logic [3:0]        kind;
		logic              lost;
		logic [31:0]       now;
	} table_req_t;

	// a directed row; a hand-typed result is used only where it is obvious
	typedef struct packed {
		table_req_t req;
		logic       has_want;
		result_t    want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 171;
	localparam int POOL_SIZE = 24;

	// block ports, the inputs all known from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              cmd = CMD_SIGHT;
	logic [47:0]       address = '0;
	logic signed [7:0] signal_strength = '0;
	logic [3:0]        device_kind = '0;
	logic              lost_flag = 1'b0;
	logic [31:0]       now_ms = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        outcome;
	logic [3:0]        slot_index;
	logic [4:0]        live_entries;
	logic [4:0]        dropped_entries;
	logic              cfg_wr_en = 1'b0;
	logic [31:0]       cfg_wr_data = '0;

	// shadow copy of the table, the live count and the stale limit
	entry_t      shadow_table [TABLE_DEPTH_DEF];
	int unsigned shadow_live = 0;
	logic [31:0] shadow_limit = STALE_RESET;

	// results owed by the block, oldest first
	result_t awaited_results [$];

	directed_row_t directed_rows [DIRECTED_ROWS];
	logic [47:0]   addr_pool [POOL_SIZE];
	logic [31:0]   wall_ms;

	int mismatches = 0;
	int requests_sent = 0;
	int sweeps_sent = 0;
	int results_seen = 0;
	int limit_writes = 0;
	int outcome_tally [4] = '{0, 0, 0, 0};
	bit quiet_tail = 1'b0;
	int stall_left = 0;

	address_table_with_stale_replace dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.address        (address),
		.signal_strength(signal_strength),
		.device_kind    (device_kind),
		.lost_flag      (lost_flag),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outcome        (outcome),
		.slot_index     (slot_index),
		.live_entries   (live_entries),
		.dropped_entries(dropped_entries),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#(10_000_000);
		$display("timeout: run did not finish, %0d results still owed", awaited_results.size());
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// works out the result of one request and moves the shadow table on
	function automatic result_t predict_table_step(input table_req_t r);
		result_t     res;
		int unsigned i;
		int unsigned kept;
		int unsigned pick;
		bit          found;
		logic [31:0] age;
		found = 1'b0;
		pick = 0;
		res.dropped = '0;
		if (r.cmd == CMD_SIGHT) begin
			// first live entry with the same address wins
			for (i = 0; i < shadow_live; i++) begin
				if (!found && shadow_table[i].address == r.address) begin
					found = 1'b1;
					pick = i;
				end
			end
			if (found) begin
				res.outcome = OUT_REFRESH;
			end else if (shadow_live < TABLE_DEPTH_DEF) begin
				pick = shadow_live;
				shadow_live++;
				res.outcome = OUT_INSERT;
			end else begin
				// smallest stored time as a plain unsigned value, lowest slot on a tie
				for (i = 1; i < shadow_live; i++)
					if (shadow_table[i].last_seen < shadow_table[pick].last_seen)
						pick = i;
				res.outcome = OUT_REPLACE;
			end
			shadow_table[pick] = '{r.address, r.strength, r.kind, r.lost, r.now};
			res.slot = pick[3:0];
		end else begin
			// keep entries whose wrapping age is within the limit, packed in order
			kept = 0;
			for (i = 0; i < shadow_live; i++) begin
				age = r.now - shadow_table[i].last_seen;
				if (age <= shadow_limit) begin
					shadow_table[kept] = shadow_table[i];
					kept++;
				end
			end
			res.dropped = 5'(shadow_live - kept);
			shadow_live = kept;
			res.outcome = OUT_SWEEP;
			res.slot = '0;
		end
		res.live = 5'(shadow_live);
		return res;
	endfunction

	// holds the request on the channel until the block takes it
	task automatic offer_request(input table_req_t r, input logic has_want, input result_t want);
		result_t predicted;
		@(negedge clk);
		cmd = r.cmd;
		address = r.address;
		signal_strength = r.strength;
		device_kind = r.kind;
		lost_flag = r.lost;
		now_ms = r.now;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = predict_table_step(r);
		awaited_results.push_back(has_want ? want : predicted);
		requests_sent++;
		if (r.cmd == CMD_SWEEP)
			sweeps_sent++;
	endtask

	task automatic sender_gap(input int cycles);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic maybe_sender_gap();
		if (!quiet_tail && $urandom_range(0, 5) == 0)
			sender_gap($urandom_range(1, 14));
	endtask

	// idle the sender until every owed result is back, then write the stale limit
	task automatic drain_then_set_limit(input logic [31:0] limit);
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = limit;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		shadow_limit = limit;
		limit_writes++;
	endtask

	function automatic directed_row_t stim_row(input logic c, input logic [47:0] a,
			input logic signed [7:0] s, input logic [3:0] k, input logic l,
			input logic [31:0] t, input logic has_want, input result_t want);
		directed_row_t row;
		row.req = '{c, a, s, k, l, t};
		row.has_want = has_want;
		row.want = want;
		return row;
	endfunction

	function automatic void load_directed_rows();
		result_t     none;
		int          i;
		logic [31:0] seen;
		none = '{OUT_REFRESH, 4'd0, 5'd0, 5'd0};
		// lowest address, kind zero, time zero into an empty table
		directed_rows[0] = stim_row(CMD_SIGHT, 48'h0, 8'sd127, 4'd0, 1'b0, 32'd0,
			1'b1, '{OUT_INSERT, 4'd0, 5'd1, 5'd0});
		// all-ones address, weakest signal, top kind, lost, last tick before the wrap
		directed_rows[1] = stim_row(CMD_SIGHT, 48'hFFFF_FFFF_FFFF, -8'sd128, 4'd15, 1'b1,
			32'hFFFF_FFFF, 1'b1, '{OUT_INSERT, 4'd1, 5'd2, 5'd0});
		directed_rows[2] = stim_row(CMD_SIGHT, 48'h0, -8'sd40, 4'd3, 1'b0, 32'd100,
			1'b1, '{OUT_REFRESH, 4'd0, 5'd2, 5'd0});
		// age exactly at the reset limit survives while the wrapped entry is dropped; next, one past it
		directed_rows[3] = stim_row(CMD_SWEEP, 48'h0, 8'sd0, 4'd0, 1'b0, 32'd30100,
			1'b1, '{OUT_SWEEP, 4'd0, 5'd1, 5'd1});
		directed_rows[4] = stim_row(CMD_SWEEP, 48'h0, 8'sd0, 4'd0, 1'b0, 32'd30101,
			1'b1, '{OUT_SWEEP, 4'd0, 5'd0, 5'd1});
		// sweep of an empty table
		directed_rows[5] = stim_row(CMD_SWEEP, 48'hFFFF_FFFF_FFFF, 8'sd0, 4'd0, 1'b0, 32'd0,
			1'b1, '{OUT_SWEEP, 4'd0, 5'd0, 5'd0});
		// fill all sixteen slots: a tie for the oldest time at slots 5 and 9, and
		// slot 12 oldest by wrapping age but largest as an unsigned number
		for (i = 0; i < 16; i++) begin
			if (i == 5 || i == 9)
				seen = 32'd500;
			else if (i == 12)
				seen = 32'hFFFF_FFF0;
			else
				seen = 32'd2000 + 32'(10 * i);
			directed_rows[6 + i] = stim_row(CMD_SIGHT,
				48'h00A5_0000_0000 | 48'(i * 32'h0101_0103),
				8'(-60 + i), 4'(i), 1'(i), seen, 1'b0, none);
		end
		directed_rows[22] = stim_row(CMD_SIGHT, 48'h0000_0000_0001, 8'sd5, 4'd7, 1'b1, 32'd3000,
			1'b1, '{OUT_REPLACE, 4'd5, 5'd16, 5'd0});
		directed_rows[23] = stim_row(CMD_SIGHT, 48'h8000_0000_0000, -8'sd5, 4'd8, 1'b0, 32'd3000,
			1'b1, '{OUT_REPLACE, 4'd9, 5'd16, 5'd0});
		// sweep of a full table that keeps a scattered set and packs it down
		directed_rows[24] = stim_row(CMD_SWEEP, 48'h0, 8'sd0, 4'd0, 1'b0, 32'd2075, 1'b0, none);
	endfunction

	function automatic table_req_t random_request();
		table_req_t r;
		r.cmd = ($urandom_range(0, 9) == 0) ? CMD_SWEEP : CMD_SIGHT;
		// mostly a known pool so hits and full-table replacements are common
		if ($urandom_range(0, 19) < 17)
			r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			r.address = {16'($urandom), 32'($urandom)};
		r.strength = 8'($urandom);
		r.kind = 4'($urandom);
		r.lost = 1'($urandom);
		// time mostly creeps forward, now and then jumps anywhere
		if ($urandom_range(0, 49) == 0)
			wall_ms = $urandom;
		else
			wall_ms = wall_ms + $urandom_range(0, 1500);
		r.now = wall_ms;
		return r;
	endfunction

	// receiver: random stall bursts, none in the closing phase
	always @(negedge clk) begin
		if (quiet_tail) begin
			out_ready = 1'b1;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(1, 14) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			outcome_tally[outcome]++;
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("result with nothing owed: outcome %0d slot %0d live %0d",
					outcome, slot_index, live_entries));
			end else begin
				want = awaited_results.pop_front();
				if (outcome !== want.outcome || slot_index !== want.slot ||
						live_entries !== want.live || dropped_entries !== want.dropped)
					flag_mismatch($sformatf(
						"result %0d: got outcome %0d slot %0d live %0d dropped %0d, want %0d %0d %0d %0d",
						results_seen, outcome, slot_index, live_entries, dropped_entries,
						want.outcome, want.slot, want.live, want.dropped));
			end
		end
	end

	initial begin
		logic [31:0] limits [PHASES];
		int          p;
		int          n;
		table_req_t  r;
		result_t     none;
		none = '{OUT_REFRESH, 4'd0, 5'd0, 5'd0};
		limits = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'($urandom), 32'd5000, 32'd30000};
		for (n = 0; n < POOL_SIZE; n++)
			addr_pool[n] = {16'($urandom), 32'($urandom)};
		wall_ms = $urandom;
		load_directed_rows();

		// reset held, then released away from the clock edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table runs against the reset value of the stale limit
		for (n = 0; n < DIRECTED_ROWS; n++) begin
			maybe_sender_gap();
			offer_request(directed_rows[n].req, directed_rows[n].has_want, directed_rows[n].want);
		end

		// random phases, each with its own stale limit written while idle
		for (p = 0; p < PHASES; p++) begin
			drain_then_set_limit(limits[p]);
			quiet_tail = (p == PHASES - 1);
			for (n = 0; n < PHASE_REQUESTS; n++) begin
				maybe_sender_gap();
				r = random_request();
				offer_request(r, 1'b0, none);
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		// a walk of a full table plus the output register
		repeat (30) @(posedge clk);

		$display("ran %0d requests (%0d sweeps) across %0d stale limit writes, %0d results back",
			requests_sent, sweeps_sent, limit_writes, results_seen);
		$display("outcomes seen: refresh %0d, insert %0d, replace %0d, sweep %0d",
			outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3]);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/att_pkg.sv
hw/rtl/att_ram.sv
hw/rtl/att_seq.sv
hw/rtl/address_table_with_stale_replace.sv
hw/rtl/att_checker.sv
tb/sv/address_table_with_stale_replace_tb.sv
